// File: src/fir_filter_assert.svh
// Assertion helpers shared by the filter modules.
`ifndef FIR_FILTER_ASSERT_SVH
`define FIR_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FIR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fir_pkg.sv
package fir_pkg;

    localparam int SMP_W      = 16;
    localparam int CIDX_W     = 6;
    localparam int TAPC_W     = 7;
    localparam int FRAC_BITS  = SMP_W - 1;
    localparam int PROD_W     = 2 * SMP_W;
    localparam logic [TAPC_W-1:0] TAPC_RESET = 7'd64;

    typedef enum logic {
        MODE_FILTER = 1'b0,
        MODE_COEF   = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_RUN   = 2'd2
    } t_seq_state;

    // One tap step handed from the sequencer to the MAC pipeline.
    typedef struct packed {
        logic issue;
        logic live;
        logic first;
        logic last;
    } t_mac_cmd;

endpackage

// File: src/fir_if.sv
interface fir_in_if
    import fir_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SMP_W-1:0]  sample_in;
    logic              block_start;
    logic [CIDX_W-1:0] coef_index;
    logic [SMP_W-1:0]  coef_value;

    modport source (
        output valid, mode, sample_in, block_start, coef_index, coef_value,
        input  ready
    );
    modport sink (
        input  valid, mode, sample_in, block_start, coef_index, coef_value,
        output ready
    );
endinterface

interface fir_out_if
    import fir_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] filtered_out;
    logic             saturated;

    modport source (
        output valid, filtered_out, saturated,
        input  ready
    );
    modport sink (
        input  valid, filtered_out, saturated,
        output ready
    );
endinterface

// File: src/fir_ram.sv
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fir_seq.sv
`include "fir_filter_assert.svh"

module fir_seq
    import fir_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [TAPC_W-1:0]    i_cfg_wr_data,
    fir_in_if.sink               i_smp,
    input  logic                 i_mac_busy,
    output logic                 o_coef_we,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_coef_waddr,
    output logic [SMP_W-1:0]     o_coef_wdata,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_coef_raddr,
    output logic                 o_hist_we,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_hist_waddr,
    output logic [SMP_W-1:0]     o_hist_wdata,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_hist_raddr,
    output t_mac_cmd             o_cmd
);

    localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCW = $clog2(MAX_TAPS + 1);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [TCW-1:0] FULL_CNT  = TCW'(MAX_TAPS);

    t_seq_state        r_state, n_state;
    logic [TAPC_W-1:0] r_tap_count, n_tap_count;
    logic [AW-1:0]     r_newest, n_newest;
    logic [TCW-1:0]    r_fill, n_fill;
    logic [TCW-1:0]    r_taps, n_taps;
    logic [AW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_rd_pos, n_rd_pos;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;

    logic           accept;
    logic           is_filter;
    logic           idx_ok;
    logic [AW-1:0]  newest_inc;
    logic [TCW-1:0] taps_eff;
    logic [TCW-1:0] fill_next;
    logic           step_last;

    assign i_smp.ready = (r_state == ST_IDLE) && !i_mac_busy;
    assign accept      = i_smp.valid && i_smp.ready;
    assign is_filter   = (i_smp.mode == MODE_FILTER);
    assign idx_ok      = (int'(i_smp.coef_index) < MAX_TAPS);
    assign newest_inc  = (r_newest == LAST_ADDR) ? '0 : r_newest + 1'b1;
    assign step_last   = (TCW'(r_k) == r_taps - 1'b1);

    // Tap count zero acts as one tap; anything beyond the store depth is clipped.
    always_comb begin
        if (r_tap_count == '0) begin
            taps_eff = TCW'(1);
        end else if (int'(r_tap_count) > MAX_TAPS) begin
            taps_eff = FULL_CNT;
        end else begin
            taps_eff = TCW'(r_tap_count);
        end
    end

    // The history is written in ring order from the last clear, so a tap k back
    // holds real data only if k is below the count of samples since then.
    always_comb begin
        if (i_smp.block_start) begin
            fill_next = TCW'(1);
        end else if (r_fill == FULL_CNT) begin
            fill_next = r_fill;
        end else begin
            fill_next = r_fill + 1'b1;
        end
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            o_coef_we    = 1'b1;
            o_coef_waddr = r_clr_addr;
            o_coef_wdata = '0;
        end else begin
            o_coef_we    = accept && !is_filter && idx_ok;
            o_coef_waddr = AW'(i_smp.coef_index);
            o_coef_wdata = i_smp.coef_value;
        end
    end

    assign o_hist_we    = accept && is_filter;
    assign o_hist_waddr = newest_inc;
    assign o_hist_wdata = i_smp.sample_in;
    assign o_coef_raddr = r_k;
    assign o_hist_raddr = r_rd_pos;

    assign o_cmd.issue = (r_state == ST_RUN);
    assign o_cmd.live  = (TCW'(r_k) < r_fill);
    assign o_cmd.first = (r_k == '0);
    assign o_cmd.last  = step_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_tap_count <= TAPC_RESET;
            r_newest    <= '0;
            r_fill      <= '0;
            r_taps      <= TCW'(1);
            r_k         <= '0;
            r_rd_pos    <= '0;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_tap_count <= n_tap_count;
            r_newest    <= n_newest;
            r_fill      <= n_fill;
            r_taps      <= n_taps;
            r_k         <= n_k;
            r_rd_pos    <= n_rd_pos;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_tap_count = i_cfg_wr_en ? i_cfg_wr_data : r_tap_count;
        n_newest    = r_newest;
        n_fill      = r_fill;
        n_taps      = r_taps;
        n_k         = r_k;
        n_rd_pos    = r_rd_pos;
        n_clr_addr  = r_clr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && is_filter) begin
                    n_newest = newest_inc;
                    n_fill   = fill_next;
                    n_taps   = taps_eff;
                    n_k      = '0;
                    n_rd_pos = newest_inc;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_k      = r_k + 1'b1;
                    n_rd_pos = (r_rd_pos == '0) ? LAST_ADDR : r_rd_pos - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `FIR_ASSERT_SAME(a_tap_in_range, i_clk, i_rst_n, r_state == ST_RUN,
        TCW'(r_k) < r_taps, "tap index ran past the tap count")
    `FIR_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1,
        int'(r_fill) <= MAX_TAPS, "history fill count above store depth")
    `FIR_ASSERT_NEXT(a_run_starts_newest, i_clk, i_rst_n, accept && is_filter,
        r_state == ST_RUN && r_k == '0 && o_hist_raddr == $past(o_hist_waddr),
        "filter run does not start at the newest sample")

endmodule

// File: src/fir_mac.sv
`include "fir_filter_assert.svh"

module fir_mac
    import fir_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_cmd                i_cmd,
    input  logic signed [SMP_W-1:0] i_coef,
    input  logic signed [SMP_W-1:0] i_hist,
    output logic                    o_busy,
    fir_out_if.source               o_res
);

    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS + 1);
    localparam int QW    = ACC_W + 1 - FRAC_BITS;
    localparam logic signed [ACC_W:0]  RND_HALF = (ACC_W + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [QW-1:0]   Q_MAX    = QW'((2 ** (SMP_W - 1)) - 1);
    localparam logic signed [QW-1:0]   Q_MIN    = -QW'(2 ** (SMP_W - 1));

    t_mac_cmd                 r_s1, r_s2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic                     r_out_valid;
    logic [SMP_W-1:0]         r_out_data;
    logic                     r_out_sat;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W:0]    rnd;
    logic signed [QW-1:0]     q;
    logic [SMP_W-1:0]         res_data;
    logic                     res_sat;
    logic                     load_out;

    assign prod     = i_coef * i_hist;
    assign prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Round half up, then arithmetic shift by the fraction width.
    assign rnd = {r_acc[ACC_W-1], r_acc} + RND_HALF;
    assign q   = QW'(rnd >>> FRAC_BITS);

    always_comb begin
        if (q > Q_MAX) begin
            res_data = Q_MAX[SMP_W-1:0];
            res_sat  = 1'b1;
        end else if (q < Q_MIN) begin
            res_data = Q_MIN[SMP_W-1:0];
            res_sat  = 1'b1;
        end else begin
            res_data = q[SMP_W-1:0];
            res_sat  = 1'b0;
        end
    end

    assign load_out = r_done && (!r_out_valid || o_res.ready);
    assign o_busy   = r_s1.issue || r_s2.issue || r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= i_cmd;
            r_s2 <= r_s1;
            if (load_out) begin
                r_done <= 1'b0;
            end else if (r_s2.issue && r_s2.last) begin
                r_done <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.issue) begin
            r_prod <= r_s1.live ? prod : '0;
        end
        if (r_s2.issue) begin
            r_acc <= r_s2.first ? prod_ext : r_acc + prod_ext;
        end
        if (load_out) begin
            r_out_data <= res_data;
            r_out_sat  <= res_sat;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.filtered_out = r_out_data;
    assign o_res.saturated    = r_out_sat;

    `FIR_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, r_done && r_out_valid && !o_res.ready,
        r_done, "finished sum dropped while output was stalled")
    `FIR_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, r_done,
        !r_s2.issue && !r_s1.issue, "new accumulation while a sum is pending")

endmodule

// File: src/fir_filter.sv
// Channel  Dir  Port     Contents
// input    in   i_smp    mode, sample_in, block_start, coef_index, coef_value
// output   out  o_res    filtered_out, saturated
// config   in   i_cfg_*  tap_count (write enable and data)
//
// After a sample item is accepted, the next item waits until one multiply-accumulate
// per tap has run through the history and coefficient memories, followed by a
// three-stage drain (product, accumulate, rounding).
// A coefficient item is written directly while the sequencer stays idle. After reset a
// clearing pass writes zeros to every coefficient memory address with i_smp.ready low.
// A stalled output keeps its result in the output register and a new item is
// still accepted; the next finished sum then waits with i_smp.ready low.
module fir_filter
    import fir_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TAPC_W-1:0] i_cfg_wr_data,
    fir_in_if.sink            i_smp,
    fir_out_if.source         o_res
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    logic             coef_we, hist_we;
    logic [AW-1:0]    coef_waddr, coef_raddr, hist_waddr, hist_raddr;
    logic [SMP_W-1:0] coef_wdata, hist_wdata, coef_rdata, hist_rdata;
    logic             mac_busy;
    t_mac_cmd         cmd;

    fir_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_smp         (i_smp),
        .i_mac_busy    (mac_busy),
        .o_coef_we     (coef_we),
        .o_coef_waddr  (coef_waddr),
        .o_coef_wdata  (coef_wdata),
        .o_coef_raddr  (coef_raddr),
        .o_hist_we     (hist_we),
        .o_hist_waddr  (hist_waddr),
        .o_hist_wdata  (hist_wdata),
        .o_hist_raddr  (hist_raddr),
        .o_cmd         (cmd)
    );

    fir_ram #(.WIDTH(SMP_W), .DEPTH(MAX_TAPS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    fir_ram #(.WIDTH(SMP_W), .DEPTH(MAX_TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    fir_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_coef  (coef_rdata),
        .i_hist  (hist_rdata),
        .o_busy  (mac_busy),
        .o_res   (o_res)
    );

endmodule
